// ===== rtl/fbc_pkg.sv =====
// shared types, constants and hash step for the framed blob checker
`default_nettype none

package fbc_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    // byte position counter saturates at the minimum blob length
    localparam int          CNT_W     = 5;
    localparam logic [CNT_W-1:0] MIN_BLOB  = 5'd16;
    localparam logic [CNT_W-1:0] MAGIC_END = 5'd4;
    localparam logic [CNT_W-1:0] VER_END   = 5'd8;

    localparam int TAIL_N  = 8;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic CFG_CUR_VERSION = 1'b0;
    localparam logic CFG_MIN_VERSION = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_CORRUPT     = 2'd1,
        ST_MIGRATE     = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hash_en;
        logic       magic_bad;
        logic       ver_en;
        logic [1:0] ver_lane;
        logic       short_blob;
    } fbc_item_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        unique case (idx)
            2'd0: return 8'h50;
            2'd1: return 8'h54;
            2'd2: return 8'h41;
            2'd3: return 8'h53;
        endcase
    endfunction

    // one fnv-1a round; the prime is 2^40 + 0x1b3, so shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fbc_front.sv =====
// front: byte position tracking and per-byte classification
`default_nettype none

module fbc_front
    import fbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       q_full,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            push,
    output fbc_item_t       item
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign push = in_valid && !q_full;

    always_comb
    begin
        item.data       = data_byte;
        item.last       = last;
        item.hash_en    = (cnt_reg >= VER_END);
        item.magic_bad  = (cnt_reg < MAGIC_END) && (data_byte != magic_byte(cnt_reg[1:0]));
        item.ver_en     = (cnt_reg >= MAGIC_END) && (cnt_reg < VER_END);
        item.ver_lane   = cnt_reg[1:0];
        item.short_blob = (cnt_reg < (MIN_BLOB - 5'd1));
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (last)
                cnt_next = '0;
            else if (cnt_reg != MIN_BLOB)
                cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= MIN_BLOB)
        else $error("byte counter past saturation");

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push && last |=> cnt_reg == '0)
        else $error("byte counter not cleared after last item");

endmodule

`default_nettype wire

// ===== rtl/fbc_queue.sv =====
// queue of classified items between front and back
`default_nettype none

module fbc_queue
    import fbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fbc_item_t item_in,
    input  wire logic      pop,
    output logic           full,
    output logic           q_valid,
    output fbc_item_t      item_out
);

    fbc_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign item_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

// ===== rtl/fbc_back.sv =====
// back: hashing, tail delay line, header capture and status decision
`default_nettype none

module fbc_back
    import fbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire fbc_item_t   item_in,
    input  wire logic [31:0] cur_version,
    input  wire logic [31:0] min_version,
    input  wire logic        out_stall,
    output logic             pop,
    output logic             out_valid,
    output logic [1:0]       status,
    output logic [31:0]      version
);

    // per-blob state
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [7:0]  tail_reg [TAIL_N];
    logic [7:0]  tail_next [TAIL_N];
    logic        magic_reg;
    logic        magic_next;
    logic [31:0] ver_reg;
    logic [31:0] ver_next;

    // finished-blob stage
    logic        fin_valid_reg;
    logic [63:0] fin_hash_reg;
    logic [63:0] fin_stored_reg;
    logic        fin_magic_reg;
    logic        fin_short_reg;
    logic [31:0] fin_ver_reg;

    // output register
    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] version_reg;

    logic        fin_adv;
    logic        back_ready;
    logic [63:0] upd_hash;
    logic [63:0] stored;
    status_t     st_calc;

    assign fin_adv    = !out_valid_reg || !out_stall;
    assign back_ready = !fin_valid_reg || fin_adv;
    assign pop        = q_valid && back_ready;

    always_comb
    begin
        upd_hash   = item_in.hash_en ? fnv_step(hash_reg, tail_reg[0]) : hash_reg;
        magic_next = magic_reg;
        ver_next   = ver_reg;
        hash_next  = hash_reg;
        for (int i = 0; i < TAIL_N - 1; i++)
            tail_next[i] = pop ? tail_reg[i + 1] : tail_reg[i];
        tail_next[TAIL_N - 1] = pop ? item_in.data : tail_reg[TAIL_N - 1];
        stored = '0;
        for (int i = 0; i < TAIL_N; i++)
            stored[8*i +: 8] = tail_next[i];
        if (pop)
        begin
            if (item_in.last)
            begin
                hash_next  = FNV_BASIS;
                magic_next = 1'b1;
                ver_next   = '0;
            end
            else
            begin
                hash_next  = upd_hash;
                magic_next = magic_reg && !item_in.magic_bad;
                if (item_in.ver_en)
                    ver_next[8*item_in.ver_lane +: 8] = item_in.data;
            end
        end
    end

    // the version byte of the last item still counts toward the reported word
    logic [31:0] fin_ver_calc;
    always_comb
    begin
        fin_ver_calc = ver_reg;
        if (item_in.ver_en)
            fin_ver_calc[8*item_in.ver_lane +: 8] = item_in.data;
    end

    always_comb
    begin
        priority if (fin_short_reg || !fin_magic_reg || (fin_stored_reg != fin_hash_reg))
            st_calc = ST_CORRUPT;
        else if (fin_ver_reg == cur_version)
            st_calc = ST_OK;
        else if ((fin_ver_reg >= min_version) && (fin_ver_reg < cur_version))
            st_calc = ST_MIGRATE;
        else
            st_calc = ST_UNSUPPORTED;
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (pop && item_in.last)
        begin
            fin_hash_reg   <= upd_hash;
            fin_stored_reg <= stored;
            fin_magic_reg  <= magic_reg && !item_in.magic_bad;
            fin_short_reg  <= item_in.short_blob;
            fin_ver_reg    <= fin_ver_calc;
        end
        if (fin_valid_reg && fin_adv)
        begin
            status_reg  <= st_calc;
            version_reg <= fin_ver_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_BASIS;
            magic_reg     <= 1'b1;
            ver_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            magic_reg <= magic_next;
            ver_reg   <= ver_next;
            if (pop && item_in.last)
                fin_valid_reg <= 1'b1;
            else if (fin_adv)
                fin_valid_reg <= 1'b0;
            if (fin_valid_reg && fin_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign version   = version_reg;

    a_blob_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item_in.last |=> (hash_reg == FNV_BASIS) && magic_reg && (ver_reg == '0))
        else $error("blob state not cleared after last item");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_adv |=> fin_valid_reg)
        else $error("finished blob dropped while output busy");

endmodule

`default_nettype wire

// ===== rtl/framed_blob_checker_fnv1a64.sv =====
// top level of the framed blob checker with 64-bit fnv-1a checksum
// throughput: one byte item per cycle sustained while out_stall is low, back-to-back blobs included
// after the last byte is accepted, its status passes through the queue write, then
//   the back pop into the finish stage, then the output register
// the hash recurrence is one fnv round per cycle in the back unit while it pops items
// reset: async active low; blob state to fnv basis, registers to version 1
`default_nettype none

module framed_blob_checker_fnv1a64
    import fbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    // status channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      version,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    // version registers; the user must write them only while idle, the block does not enforce it
    logic [31:0] cur_version_reg;
    logic [31:0] min_version_reg;

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_valid;
    fbc_item_t   front_item;
    fbc_item_t   back_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_version_reg <= 32'd1;
            min_version_reg <= 32'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CUR_VERSION: cur_version_reg <= cfg_data;
                CFG_MIN_VERSION: min_version_reg <= cfg_data;
            endcase
        end
    end

    // input stalls only on a full queue, which fills when the output side holds the back
    assign in_stall = q_full;

    // front: position counter and per-byte classification
    fbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .q_full    (q_full),
        .data_byte (data_byte),
        .last      (last),
        .push      (push),
        .item      (front_item)
    );

    // short queue decouples the front from the back
    fbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .item_out (back_item)
    );

    // back: hash, tail line, header capture, status and output register
    fbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .item_in     (back_item),
        .cur_version (cur_version_reg),
        .min_version (min_version_reg),
        .out_stall   (out_stall),
        .pop         (pop),
        .out_valid   (out_valid),
        .status      (status),
        .version     (version)
    );

endmodule

`default_nettype wire

// ===== tb/framed_blob_checker_fnv1a64_checker.sv =====
// status checker for the framed blob checker: tracks blobs and compares status items
module blob_status_checker
    import fbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] version,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FNV_MULT   = 64'h0000_0100_0000_01b3;
    localparam logic [31:0] BLOB_MAGIC = "PTAS";

    typedef struct packed {
        status_t     status;
        logic [31:0] version;
    } blob_verdict_t;

    blob_verdict_t verdict_q[$];
    blob_verdict_t oldest;

    logic [31:0] ok_version;
    logic [31:0] oldest_migratable;

    logic [63:0] hash_acc;
    logic [7:0]  tail [8];
    logic [4:0]  seen;
    logic        magic_ok;
    logic [31:0] ver_word;

    task automatic clear_blob_state();
        hash_acc = FNV_BASIS;
        for (int i = 0; i < 8; i++)
            tail[i] = 8'd0;
        seen     = '0;
        magic_ok = 1'b1;
        ver_word = '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("checker: %0t ns %s", $realtime, msg);
        fail_count++;
    endtask

    // one accepted byte; on the last byte a verdict is queued
    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        logic [63:0]   stored;
        blob_verdict_t v;
        if (seen < 4)
        begin
            if (b != BLOB_MAGIC[31 - 8*seen -: 8])
                magic_ok = 1'b0;
        end
        else if (seen < 8)
        begin
            ver_word[8*(seen - 4) +: 8] = b;
        end
        if (seen >= 8)
            hash_acc = (hash_acc ^ {56'd0, tail[0]}) * FNV_MULT;
        for (int i = 0; i < 7; i++)
            tail[i] = tail[i + 1];
        tail[7] = b;
        if (seen < MIN_BLOB)
            seen = seen + 1'b1;
        if (is_last)
        begin
            for (int i = 0; i < 8; i++)
                stored[8*i +: 8] = tail[i];
            if (seen < MIN_BLOB || !magic_ok || stored != hash_acc)
                v.status = ST_CORRUPT;
            else if (ver_word == ok_version)
                v.status = ST_OK;
            else if (ver_word >= oldest_migratable && ver_word < ok_version)
                v.status = ST_MIGRATE;
            else
                v.status = ST_UNSUPPORTED;
            v.version = ver_word;
            verdict_q = {verdict_q, v};
            clear_blob_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_version        = 32'd1;
            oldest_migratable = 32'd1;
            clear_blob_state();
            verdict_q.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_CUR_VERSION)
                    ok_version = cfg_data;
                else
                    oldest_migratable = cfg_data;
            end
            if (in_valid && !in_stall)
                absorb_byte(data_byte, last);
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "status item with none expected: status %0d version %0h",
                        status, version));
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, oldest.status));
                    if (version !== oldest.version)
                        report_mismatch($sformatf("version got %0h expected %0h",
                                                  version, oldest.version));
                end
            end
            outstanding <= verdict_q.size();
        end
    end

endmodule

// ===== tb/tb_framed_blob_checker_fnv1a64.sv =====
// testbench top for the framed blob checker: stimulus, version phases and verdict
module tb_framed_blob_checker_fnv1a64;
    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam logic [63:0] FNV_MULT        = 64'h0000_0100_0000_01b3;
    localparam logic [31:0] BLOB_MAGIC      = "PTAS";
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          PHASE_ITEMS     = 135;
    localparam int          PHASE_BLOBS     = 5;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] version;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;

    // idle chances in percent; the sender's is only touched by the stimulus process
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    logic hold_off_req = 1'b0;
    logic hold_off_done = 1'b0;

    // version registers as last written, used to aim blob versions at the boundaries
    logic [31:0] cfg_cur;
    logic [31:0] cfg_min;

    // bytes of the blob being built, oldest first
    logic [7:0] blob_q[$];

    framed_blob_checker_fnv1a64 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .version   (version),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blob_status_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .version     (version),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver side: random stall bursts, plus one long hold-off so the block backs up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one byte item, with an optional idle burst in front, and wait until taken
    task automatic send_item(input logic [7:0] b, input logic l);
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // send the whole blob, marking its final byte
    task automatic send_blob();
        foreach (blob_q[i])
            send_item(blob_q[i], i == blob_q.size() - 1);
    endtask

    // drain all pending status items, let the pipeline settle, then write both versions
    task automatic settle_and_configure(input logic [31:0] cur_v, input logic [31:0] min_v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // leave some margin before writing the versions
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CUR_VERSION;
        cfg_data  <= cur_v;
        @(posedge clk);
        cfg_index <= CFG_MIN_VERSION;
        cfg_data  <= min_v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_cur = cur_v;
        cfg_min = min_v;
    endtask

    // well-formed blob: magic, little-endian version, body, little-endian fnv-1a of all that;
    // spoil_magic >= 0 breaks that magic byte but keeps the checksum consistent
    task automatic build_framed_blob(input logic [31:0] ver, input int body_len,
                                     input int spoil_magic);
        logic [63:0] digest;
        logic [7:0]  flip;
        blob_q.delete();
        for (int i = 0; i < 4; i++)
            blob_q = {blob_q, BLOB_MAGIC[31 - 8*i -: 8]};
        if (spoil_magic >= 0)
        begin
            flip = $urandom_range(1, 255);
            blob_q[spoil_magic] = blob_q[spoil_magic] ^ flip;
        end
        for (int i = 0; i < 4; i++)
            blob_q = {blob_q, ver[8*i +: 8]};
        for (int i = 0; i < body_len; i++)
            blob_q = {blob_q, 8'($urandom())};
        digest = FNV_BASIS;
        foreach (blob_q[i])
            digest = (digest ^ {56'd0, blob_q[i]}) * FNV_MULT;
        for (int i = 0; i < 8; i++)
            blob_q = {blob_q, digest[8*i +: 8]};
    endtask

    // versions around the classification boundaries, with some fully random ones
    function automatic logic [31:0] pick_version();
        case ($urandom_range(0, 7))
            0, 1:    return cfg_cur;
            2:       return cfg_min;
            3:       return cfg_cur - 32'd1;
            4:       return cfg_min - 32'd1;
            5:       return cfg_cur + 32'd1;
            6:       return $urandom();
            default: return cfg_min + 32'($urandom_range(0, 3));
        endcase
    endfunction

    // mostly intact blobs; the rest damaged, cut short, overlong or plain noise
    task automatic send_random_blob();
        int         kind;
        int         body_len;
        int         pos;
        int         keep;
        logic [7:0] flip;
        kind     = $urandom_range(0, 99);
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (kind >= 65 && kind < 70)
            build_framed_blob(pick_version(), body_len, $urandom_range(0, 3));
        else
            build_framed_blob(pick_version(), body_len, -1);
        if (kind >= 70 && kind < 80)
        begin
            // one byte damaged anywhere, checksum included
            pos  = $urandom_range(0, blob_q.size() - 1);
            flip = $urandom_range(1, 255);
            blob_q[pos] = blob_q[pos] ^ flip;
        end
        else if (kind >= 80 && kind < 88)
        begin
            // last mark comes early, often below the minimum length
            keep = $urandom_range(1, blob_q.size() - 1);
            while (blob_q.size() > keep)
                void'(blob_q.pop_back());
        end
        else if (kind >= 88 && kind < 92)
        begin
            // stray byte after the checksum shifts the trailer
            blob_q = {blob_q, 8'($urandom())};
        end
        else if (kind >= 92)
        begin
            blob_q.delete();
            repeat ($urandom_range(1, 20))
                blob_q = {blob_q, 8'($urandom())};
        end
        send_blob();
    endtask

    task automatic run_phase(input logic [31:0] cur_v, input logic [31:0] min_v,
                             input int src_pct, input int snk_pct);
        int first_item;
        int blobs;
        settle_and_configure(cur_v, min_v);
        src_idle_pct = src_pct;
        snk_idle_pct <= snk_pct;
        first_item = items_sent;
        blobs      = 0;
        while (items_sent - first_item < PHASE_ITEMS || blobs < PHASE_BLOBS)
        begin
            send_random_blob();
            blobs++;
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] rand_cur;
        logic [31:0] rand_min;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        last      = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_CUR_VERSION;
        cfg_data  = 32'd0;
        cfg_cur   = 32'd1;
        cfg_min   = 32'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single-byte blobs at both byte extremes, then an intact minimum blob
        settle_and_configure(32'd1, 32'd1);
        send_item(8'h00, 1'b1);
        send_item(8'hff, 1'b1);
        build_framed_blob(32'd1, 0, -1);
        send_blob();

        // random phases over several version windows, extremes included
        run_phase(32'd1, 32'd1, 20, 20);
        // long receiver hold-off while the sender keeps pushing; drain first so
        // the hold-off lands on a phase that is offering items
        settle_and_configure(32'd0, 32'd0);
        hold_off_req <= 1'b1;
        run_phase(32'd0, 32'd0, 0, 0);
        run_phase(32'hffff_ffff, 32'd0, 30, 10);
        run_phase(32'hffff_ffff, 32'hffff_ffff, 10, 40);
        run_phase(32'd100, 32'd90, 25, 25);
        // min above current: nothing classifies as needing migration
        run_phase(32'd5, 32'd10, 15, 15);
        rand_cur = $urandom();
        rand_min = $urandom();
        // closing stretch runs at full rate on both sides
        run_phase(rand_cur, rand_min, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== framed_blob_checker_fnv1a64.f =====
rtl/fbc_pkg.sv
rtl/fbc_front.sv
rtl/fbc_queue.sv
rtl/fbc_back.sv
rtl/framed_blob_checker_fnv1a64.sv
tb/framed_blob_checker_fnv1a64_checker.sv
tb/tb_framed_blob_checker_fnv1a64.sv
